>>> rtl/core/first_fit_heap_allocator_defines.svh
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_defines
// assertion macros for the allocator rtl
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FFH_ASSERT_NOW(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FFH_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

>>> rtl/core/ffh_pkg.sv
// ---------------------------------------------------------------------------
// ffh_pkg
// types, constants and cell commands of the first-fit heap allocator
// ---------------------------------------------------------------------------
package ffh_pkg;

    localparam int FFH_HEAP_BYTES   = 1024;
    localparam int FFH_HEADER_BYTES = 16;
    localparam int FFH_MAX_BLOCKS   = 64;

    localparam int REQW = 10;
    // byte address / size width inside the heap
    localparam int AW   = $clog2(FFH_HEAP_BYTES);
    // width for sums and compares against request fields
    localparam int SW   = ((AW > REQW) ? AW : REQW) + 2;

    typedef logic [AW-1:0] addr_t;
    typedef logic [SW-1:0] sum_t;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    typedef struct packed {
        logic  valid;
        logic  free;
        addr_t start;
        addr_t size;
    } entry_t;

    typedef struct packed {
        entry_t ent;
        logic   sel;
    } link_t;

    typedef enum logic [3:0] {
        OP_HOLD,
        OP_MATCH_ALLOC,
        OP_MATCH_FREE,
        OP_PICK,
        OP_MARK_USED,
        OP_SPLIT,
        OP_FREE_MARK,
        OP_FREE_FWD,
        OP_MERGE_BWD
    } cell_op_t;

    typedef struct packed {
        cell_op_t        op;
        logic [REQW-1:0] asz;
        logic [REQW-1:0] foff;
    } cell_cmd_t;

    // everything but hit is gated by the cell's select flag
    typedef struct packed {
        logic  hit;
        addr_t start;
        logic  big;
        logic  rfree;
        logic  lfree;
    } cell_info_t;

endpackage

>>> rtl/core/first_fit_heap_allocator.sv
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit heap allocator with split and two-sided coalescing
// ---------------------------------------------------------------------------
//  channel   handshake        word
//  --------  ---------------  --------------------------------------
//  request   start & !busy    req_type, alloc_size, free_offset
//  result    done (strobe)    status, payload_offset
//
//  done rises after match, first-hit pick, selected-cell readout and one
//  update step (free adds one for the backward merge); a new request may
//  be accepted in the cycle that done is high. reset puts the whole heap
//  in slot zero as one free block; the table is a row of cells that shift
//  one place on a split or merge. results cannot be stalled.
// ---------------------------------------------------------------------------
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator
    import ffh_pkg::*;
#(
    parameter int MAX_BLOCKS = FFH_MAX_BLOCKS
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            req_type,
    input  logic [REQW-1:0] alloc_size,
    input  logic [REQW-1:0] free_offset,
    output logic            done,
    output logic [1:0]      status,
    output logic [REQW-1:0] payload_offset
);

    cell_cmd_t             cmd;
    logic [MAX_BLOCKS-1:0] pick_vec;
    logic [MAX_BLOCKS-1:0] after_vec;
    link_t                 links [MAX_BLOCKS];
    cell_info_t            infos [MAX_BLOCKS];

    ffh_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .req_type       (req_type),
        .alloc_size     (alloc_size),
        .free_offset    (free_offset),
        .busy           (busy),
        .done           (done),
        .status         (status),
        .payload_offset (payload_offset),
        .cmd            (cmd),
        .pick           (pick_vec),
        .after          (after_vec),
        .info           (infos)
    );

    for (genvar k = 0; k < MAX_BLOCKS; k++)
    begin : g_cell
        link_t left_in;
        link_t right_in;

        if (k == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_left
            assign left_in = links[k-1];
        end

        if (k == MAX_BLOCKS - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_right
            assign right_in = links[k+1];
        end

        ffh_cell #(
            .HEAD_CELL (k == 0)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .pick  (pick_vec[k]),
            .after (after_vec[k]),
            .left  (left_in),
            .right (right_in),
            .self  (links[k]),
            .info  (infos[k])
        );
    end

    `FFH_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted word did not start")
    `FFH_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done held longer than one cycle")
    `FFH_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy, "result shown while still busy")
    `FFH_ASSERT_NOW(a_status_code, clk, rst_n, done, status == ST_DONE || status == ST_NOFIT || status == ST_BADFREE, "bad status code")
    `FFH_ASSERT_NOW(a_fail_offset, clk, rst_n, done && status != ST_DONE, payload_offset == '0, "failed request with nonzero offset")

endmodule

>>> rtl/core/ffh_cell.sv
// ---------------------------------------------------------------------------
// ffh_cell
// one table slot: holds a block entry, matches it and shifts with neighbors
// ---------------------------------------------------------------------------
module ffh_cell
    import ffh_pkg::*;
#(
    parameter bit HEAD_CELL = 1'b0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_cmd_t  cmd,
    input  logic       pick,
    input  logic       after,
    input  link_t      left,
    input  link_t      right,
    output link_t      self,
    output cell_info_t info
);

    localparam addr_t  INIT_SIZE = AW'(FFH_HEAP_BYTES - FFH_HEADER_BYTES);
    localparam entry_t HEAD_ENT  = '{valid: 1'b1, free: 1'b1, start: '0, size: INIT_SIZE};
    localparam entry_t RST_ENT   = HEAD_CELL ? HEAD_ENT : entry_t'('0);
    localparam sum_t   HDR       = SW'(FFH_HEADER_BYTES);

    entry_t ent_reg, ent_next;
    logic   sel_reg, sel_next;
    logic   aft_reg, aft_next;
    logic   hit_reg, hit_next;

    sum_t   asz_w;
    sum_t   size_w;
    logic   fits;
    logic   big;
    logic   addr_hit;

    assign asz_w    = SW'(cmd.asz);
    assign size_w   = SW'(ent_reg.size);
    assign fits     = size_w >= asz_w;
    assign big      = size_w > (asz_w + HDR);
    assign addr_hit = (SW'(ent_reg.start) + HDR) == SW'(cmd.foff);

    always_comb
    begin
        ent_next = ent_reg;
        sel_next = sel_reg;
        aft_next = aft_reg;
        hit_next = hit_reg;
        unique case (cmd.op)
            OP_MATCH_ALLOC:
            begin
                hit_next = ent_reg.valid & ent_reg.free & fits;
            end
            OP_MATCH_FREE:
            begin
                hit_next = ent_reg.valid & ~ent_reg.free & addr_hit;
            end
            OP_PICK:
            begin
                sel_next = pick;
                aft_next = after;
            end
            OP_MARK_USED:
            begin
                if (sel_reg)
                begin
                    ent_next.free = 1'b0;
                end
            end
            OP_SPLIT:
            begin
                priority if (sel_reg)
                begin
                    ent_next.size = AW'(cmd.asz);
                    ent_next.free = 1'b0;
                end
                else if (left.sel)
                begin
                    // free remainder behind the block just handed out
                    ent_next.valid = 1'b1;
                    ent_next.free  = 1'b1;
                    ent_next.start = AW'(SW'(left.ent.start) + HDR + asz_w);
                    ent_next.size  = AW'(SW'(left.ent.size) - HDR - asz_w);
                end
                else if (aft_reg)
                begin
                    ent_next = left.ent;
                end
                else
                begin
                    ent_next = ent_reg;
                end
            end
            OP_FREE_MARK:
            begin
                if (sel_reg)
                begin
                    ent_next.free = 1'b1;
                end
            end
            OP_FREE_FWD:
            begin
                priority if (sel_reg)
                begin
                    ent_next.free = 1'b1;
                    ent_next.size = AW'(size_w + HDR + SW'(right.ent.size));
                end
                else if (aft_reg)
                begin
                    ent_next = right.ent;
                end
                else
                begin
                    ent_next = ent_reg;
                end
            end
            OP_MERGE_BWD:
            begin
                // the slot ahead of the freed block absorbs it
                priority if (right.sel)
                begin
                    ent_next.size = AW'(size_w + HDR + SW'(right.ent.size));
                end
                else if (sel_reg || aft_reg)
                begin
                    ent_next = right.ent;
                end
                else
                begin
                    ent_next = ent_reg;
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= RST_ENT;
            sel_reg <= 1'b0;
            aft_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            ent_reg <= ent_next;
            sel_reg <= sel_next;
            aft_reg <= aft_next;
            hit_reg <= hit_next;
        end
    end

    assign self.ent   = ent_reg;
    assign self.sel   = sel_reg;

    assign info.hit   = hit_reg;
    assign info.start = sel_reg ? ent_reg.start : '0;
    assign info.big   = sel_reg & big;
    assign info.rfree = sel_reg & right.ent.valid & right.ent.free;
    assign info.lfree = sel_reg & left.ent.valid & left.ent.free;

endmodule

>>> rtl/core/ffh_ctrl.sv
// ---------------------------------------------------------------------------
// ffh_ctrl
// request sequencer: drives cell commands, picks the first hit, reports
// ---------------------------------------------------------------------------
module ffh_ctrl
    import ffh_pkg::*;
#(
    parameter int MAX_BLOCKS = FFH_MAX_BLOCKS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  req_type,
    input  logic [REQW-1:0]       alloc_size,
    input  logic [REQW-1:0]       free_offset,
    output logic                  busy,
    output logic                  done,
    output logic [1:0]            status,
    output logic [REQW-1:0]       payload_offset,
    output cell_cmd_t             cmd,
    output logic [MAX_BLOCKS-1:0] pick,
    output logic [MAX_BLOCKS-1:0] after,
    input  cell_info_t            info [MAX_BLOCKS]
);

    localparam int   CNTW = $clog2(MAX_BLOCKS + 1);
    localparam sum_t HDR  = SW'(FFH_HEADER_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_PICK,
        S_INFO,
        S_APPLY,
        S_BWD
    } state_t;

    state_t            state_reg;
    logic              req_reg;
    logic [REQW-1:0]   asz_reg;
    logic [REQW-1:0]   foff_reg;
    logic              found_reg;
    addr_t             sstart_reg;
    logic              big_reg;
    logic              rfree_reg;
    logic              lfree_reg;
    logic [CNTW-1:0]   count_reg;
    logic              done_reg;
    logic [1:0]        status_reg;
    logic [REQW-1:0]   off_reg;

    logic [MAX_BLOCKS-1:0] hit_vec;
    logic [MAX_BLOCKS-1:0] onehot;
    addr_t                 red_start;
    logic                  red_big;
    logic                  red_rfree;
    logic                  red_lfree;
    logic                  split_ok;
    sum_t                  off_sum;

    always_comb
    begin
        red_start = '0;
        red_big   = 1'b0;
        red_rfree = 1'b0;
        red_lfree = 1'b0;
        for (int k = 0; k < MAX_BLOCKS; k++)
        begin
            hit_vec[k] = info[k].hit;
            red_start  = red_start | info[k].start;
            red_big    = red_big | info[k].big;
            red_rfree  = red_rfree | info[k].rfree;
            red_lfree  = red_lfree | info[k].lfree;
        end
    end

    // lowest set hit, then everything above it
    assign onehot = hit_vec & (~hit_vec + MAX_BLOCKS'(1));
    assign pick   = onehot;
    assign after  = ~(onehot - MAX_BLOCKS'(1)) & ~onehot;

    assign split_ok = big_reg && (count_reg < CNTW'(MAX_BLOCKS));
    assign off_sum  = SW'(sstart_reg) + HDR;

    always_comb
    begin
        cmd.asz  = asz_reg;
        cmd.foff = foff_reg;
        cmd.op   = OP_HOLD;
        unique case (state_reg)
            S_MATCH:
            begin
                cmd.op = (req_reg == REQ_FREE) ? OP_MATCH_FREE : OP_MATCH_ALLOC;
            end
            S_PICK:
            begin
                cmd.op = OP_PICK;
            end
            S_APPLY:
            begin
                priority if (!found_reg)
                begin
                    cmd.op = OP_HOLD;
                end
                else if (req_reg == REQ_ALLOC)
                begin
                    cmd.op = split_ok ? OP_SPLIT : OP_MARK_USED;
                end
                else
                begin
                    cmd.op = rfree_reg ? OP_FREE_FWD : OP_FREE_MARK;
                end
            end
            S_BWD:
            begin
                cmd.op = lfree_reg ? OP_MERGE_BWD : OP_HOLD;
            end
            default:
            begin
                cmd.op = OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            req_reg    <= REQ_ALLOC;
            asz_reg    <= '0;
            foff_reg   <= '0;
            found_reg  <= 1'b0;
            sstart_reg <= '0;
            big_reg    <= 1'b0;
            rfree_reg  <= 1'b0;
            lfree_reg  <= 1'b0;
            count_reg  <= CNTW'(1);
            done_reg   <= 1'b0;
            status_reg <= ST_DONE;
            off_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= req_type;
                        asz_reg   <= alloc_size;
                        foff_reg  <= free_offset;
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH:
                begin
                    state_reg <= S_PICK;
                end
                S_PICK:
                begin
                    found_reg <= |hit_vec;
                    state_reg <= S_INFO;
                end
                S_INFO:
                begin
                    sstart_reg <= red_start;
                    big_reg    <= red_big;
                    rfree_reg  <= red_rfree;
                    lfree_reg  <= red_lfree;
                    state_reg  <= S_APPLY;
                end
                S_APPLY:
                begin
                    priority if (!found_reg)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= (req_reg == REQ_ALLOC) ? ST_NOFIT : ST_BADFREE;
                        off_reg    <= '0;
                        state_reg  <= S_IDLE;
                    end
                    else if (req_reg == REQ_ALLOC)
                    begin
                        if (split_ok)
                        begin
                            count_reg <= count_reg + CNTW'(1);
                        end
                        done_reg   <= 1'b1;
                        status_reg <= ST_DONE;
                        off_reg    <= off_sum[REQW-1:0];
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        if (rfree_reg)
                        begin
                            count_reg <= count_reg - CNTW'(1);
                        end
                        state_reg <= S_BWD;
                    end
                end
                S_BWD:
                begin
                    if (lfree_reg)
                    begin
                        count_reg <= count_reg - CNTW'(1);
                    end
                    done_reg   <= 1'b1;
                    status_reg <= ST_DONE;
                    off_reg    <= '0;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign payload_offset = off_reg;

endmodule

>>> test/first_fit_heap_allocator_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// self-checking bench for the first-fit heap allocator: a short table of
// directed requests, then random allocate / free traffic in phases that fill
// and drain the heap, each result checked against a fixed value or a block-table predictor
// ---------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
    import ffh_pkg::*;

    localparam int HDR           = FFH_HEADER_BYTES;
    localparam int RANDOM_WORDS  = 1350;
    localparam int PHASE_WORDS   = 150;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DIR_ROWS      = 20;

    typedef struct packed {
        logic [1:0]      status;
        logic [REQW-1:0] offset;
    } heap_result_t;

    typedef struct packed {
        logic            rq;
        logic [REQW-1:0] asz;
        logic [REQW-1:0] foff;
        logic            fixed;
        heap_result_t    res;
    } stim_row_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic            req_type = REQ_ALLOC;
    logic [REQW-1:0] alloc_size = '0;
    logic [REQW-1:0] free_offset = '0;
    logic            busy;
    logic            done;
    logic [1:0]      status;
    logic [REQW-1:0] payload_offset;

    first_fit_heap_allocator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .alloc_size     (alloc_size),
        .free_offset    (free_offset),
        .done           (done),
        .status         (status),
        .payload_offset (payload_offset)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predicted block table, address ordered
    int blk_start [FFH_MAX_BLOCKS];
    int blk_size  [FFH_MAX_BLOCKS];
    bit blk_free  [FFH_MAX_BLOCKS];
    int blk_count;

    heap_result_t result_q [$];
    heap_result_t exp_res;

    int errors = 0;
    int cycles = 0;
    int burst_left = 0;
    int n_alloc = 0, n_nofit = 0, n_free = 0, n_badfree = 0;
    int n_fwd = 0, n_bwd = 0, peak_blocks = 1;

    // directed requests; fixed rows carry their result, the rest use the predictor
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{REQ_ALLOC, 10'd0,    10'd1023, 1'b1, '{ST_DONE,    10'd16}},
        '{REQ_FREE,  10'd1008, 10'd16,   1'b1, '{ST_DONE,    10'd0}},
        '{REQ_ALLOC, 10'd1008, 10'd0,    1'b1, '{ST_DONE,    10'd16}},
        '{REQ_ALLOC, 10'd0,    10'd0,    1'b1, '{ST_NOFIT,   10'd0}},
        '{REQ_FREE,  10'd0,    10'd0,    1'b1, '{ST_BADFREE, 10'd0}},
        '{REQ_FREE,  10'd0,    10'd1023, 1'b1, '{ST_BADFREE, 10'd0}},
        '{REQ_FREE,  10'd0,    10'd16,   1'b1, '{ST_DONE,    10'd0}},
        '{REQ_FREE,  10'd0,    10'd16,   1'b1, '{ST_BADFREE, 10'd0}},
        '{REQ_ALLOC, 10'd100,  10'd0,    1'b1, '{ST_DONE,    10'd16}},
        '{REQ_ALLOC, 10'd200,  10'd0,    1'b0, '{ST_DONE,    10'd0}},
        '{REQ_ALLOC, 10'd50,   10'd0,    1'b0, '{ST_DONE,    10'd0}},
        '{REQ_ALLOC, 10'd17,   10'd0,    1'b0, '{ST_DONE,    10'd0}},
        '{REQ_FREE,  10'd0,    10'd132,  1'b0, '{ST_DONE,    10'd0}},
        '{REQ_FREE,  10'd0,    10'd348,  1'b0, '{ST_DONE,    10'd0}},
        '{REQ_FREE,  10'd0,    10'd16,   1'b0, '{ST_DONE,    10'd0}},
        '{REQ_ALLOC, 10'd1008, 10'd0,    1'b0, '{ST_DONE,    10'd0}},
        '{REQ_ALLOC, 10'd366,  10'd0,    1'b0, '{ST_DONE,    10'd0}},
        '{REQ_FREE,  10'd0,    10'd17,   1'b0, '{ST_DONE,    10'd0}},
        '{REQ_ALLOC, 10'd0,    10'd0,    1'b0, '{ST_DONE,    10'd0}},
        '{REQ_ALLOC, 10'd1,    10'd0,    1'b0, '{ST_DONE,    10'd0}}
    };

    task automatic heap_clear();
        blk_count = 1;
        blk_start[0] = 0;
        blk_size[0] = FFH_HEAP_BYTES - HDR;
        blk_free[0] = 1'b1;
    endtask

    function automatic void heap_remove(int idx);
        for (int k = idx; k + 1 < blk_count; k++)
        begin
            blk_start[k] = blk_start[k + 1];
            blk_size[k] = blk_size[k + 1];
            blk_free[k] = blk_free[k + 1];
        end
        blk_count--;
    endfunction

    function automatic heap_result_t heap_predict(logic rq, logic [REQW-1:0] asz,
                                                  logic [REQW-1:0] foff);
        heap_result_t res;
        int hit;
        res = '{ST_DONE, '0};
        hit = -1;
        if (rq == REQ_ALLOC)
        begin
            for (int i = 0; i < blk_count && hit < 0; i++)
                if (blk_free[i] && blk_size[i] >= int'(asz))
                    hit = i;
            if (hit < 0)
            begin
                res.status = ST_NOFIT;
                n_nofit++;
                return res;
            end
            if (blk_size[hit] > int'(asz) + HDR && blk_count < FFH_MAX_BLOCKS)
            begin
                // split off the free tail right after the hit block
                for (int k = blk_count; k > hit + 1; k--)
                begin
                    blk_start[k] = blk_start[k - 1];
                    blk_size[k] = blk_size[k - 1];
                    blk_free[k] = blk_free[k - 1];
                end
                blk_start[hit + 1] = blk_start[hit] + HDR + int'(asz);
                blk_size[hit + 1] = blk_size[hit] - HDR - int'(asz);
                blk_free[hit + 1] = 1'b1;
                blk_size[hit] = int'(asz);
                blk_count++;
                if (blk_count > peak_blocks)
                    peak_blocks = blk_count;
            end
            blk_free[hit] = 1'b0;
            res.offset = REQW'(blk_start[hit] + HDR);
            n_alloc++;
            return res;
        end
        for (int i = 0; i < blk_count && hit < 0; i++)
            if (!blk_free[i] && blk_start[i] + HDR == int'(foff))
                hit = i;
        if (hit < 0)
        begin
            res.status = ST_BADFREE;
            n_badfree++;
            return res;
        end
        n_free++;
        blk_free[hit] = 1'b1;
        if (hit + 1 < blk_count && blk_free[hit + 1])
        begin
            blk_size[hit] += HDR + blk_size[hit + 1];
            heap_remove(hit + 1);
            n_fwd++;
        end
        if (hit > 0 && blk_free[hit - 1])
        begin
            blk_size[hit - 1] += HDR + blk_size[hit];
            heap_remove(hit);
            n_bwd++;
        end
        return res;
    endfunction

    // payload offset of a random block with the given free mark, -1 if none
    function automatic int pick_block(bit want_free);
        int cnt;
        int sel;
        cnt = 0;
        for (int i = 0; i < blk_count; i++)
            if (blk_free[i] == want_free)
                cnt++;
        if (cnt == 0)
            return -1;
        sel = $urandom_range(0, cnt - 1);
        for (int i = 0; i < blk_count; i++)
            if (blk_free[i] == want_free)
            begin
                if (sel == 0)
                    return blk_start[i] + HDR;
                sel--;
            end
        return -1;
    endfunction

    task automatic send_word(logic rq, logic [REQW-1:0] asz, logic [REQW-1:0] foff,
                             logic fixed, heap_result_t fixed_res);
        heap_result_t res;
        start <= 1'b1;
        req_type <= rq;
        alloc_size <= asz;
        free_offset <= foff;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        res = heap_predict(rq, asz, foff);
        result_q.push_back(fixed ? fixed_res : res);
        // bursts of back-to-back words, then a random gap
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (result_q.size() == 0)
            begin
                $error("unexpected word: status %0d payload_offset %0d",
                       status, payload_offset);
                errors++;
            end
            else
            begin
                exp_res = result_q.pop_front();
                if (status !== exp_res.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_res.status, status);
                    errors++;
                end
                if (payload_offset !== exp_res.offset)
                begin
                    $error("payload_offset: expected %0d, actual %0d",
                           exp_res.offset, payload_offset);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("first_fit_heap_allocator_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int mode;
        int alloc_pct;
        int roll;
        int target;
        logic [REQW-1:0] asz;
        logic [REQW-1:0] foff;

        heap_clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_word(dir_rows[r].rq, dir_rows[r].asz, dir_rows[r].foff,
                      dir_rows[r].fixed, dir_rows[r].res);

        mode = 0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // phases: mixed, fill with small blocks, drain
            if (n % PHASE_WORDS == 0)
                mode = $urandom_range(0, 3);
            alloc_pct = (mode == 1) ? 80 : (mode == 2) ? 15 : 50;
            roll = $urandom_range(0, 99);
            asz = REQW'($urandom_range(0, 1008));
            foff = REQW'($urandom_range(0, 1023));
            if (roll < alloc_pct)
            begin
                roll = $urandom_range(0, 99);
                if (mode == 1)
                    asz = REQW'($urandom_range(0, 16));
                else if (roll < 50)
                    asz = REQW'($urandom_range(0, 64));
                else if (roll < 80)
                    asz = REQW'($urandom_range(0, 300));
                else if (roll >= 95)
                    asz = '0;
                send_word(REQ_ALLOC, asz, foff, 1'b0, '0);
            end
            else
            begin
                roll = $urandom_range(0, 9);
                // live block most of the time, else a stray or double free
                target = (roll < 7) ? pick_block(1'b0) : (roll == 9) ? pick_block(1'b1) : -1;
                if (target >= 0)
                    foff = REQW'(target);
                send_word(REQ_FREE, asz, foff, 1'b0, '0);
            end
        end
        start <= 1'b0;

        while (result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d allocations, %0d no-fit, %0d frees and %0d bad frees",
                 n_alloc, n_nofit, n_free, n_badfree);
        $display("merged %0d forward and %0d backward, table peaked at %0d blocks",
                 n_fwd, n_bwd, peak_blocks);
        if (errors == 0)
            $display("first_fit_heap_allocator_tb OK");
        else
            $display("first_fit_heap_allocator_tb NOT OK");
        $finish;
    end

endmodule
